// ----- rtl/hasp_pkg.sv -----
// Shared constants, types and the arctangent table for the Horn aspect core.
// Used by hasp_regs and horn_aspect_3x3_core; depends on nothing else.
package hasp_pkg;

  // Elevation samples and derived datapath widths.
  localparam int ELEV_WIDTH    = 16;
  localparam int RES_W         = 16;
  localparam int GRAD_W        = ELEV_WIDTH + 3;          // difference of two weighted three-sample sums
  localparam int PROD_W        = GRAD_W + RES_W + 1;      // gradient times unsigned spacing
  localparam int CORD_W        = PROD_W + 3;              // room for CORDIC gain and sign
  localparam int ANG_FRAC      = 16;
  localparam int ANG_W         = 26;                      // signed degrees, 16 fraction bits
  localparam int DEG_W         = 9;

  // Micro-rotation count, capped by the table length.
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int N_ROT         = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int TAB_IDX_W     = 5;

  localparam logic signed [ANG_W-1:0] ANG_180  = ANG_W'(180 * (1 << ANG_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_360  = ANG_W'(360 * (1 << ANG_FRAC));
  localparam logic signed [ANG_W-1:0] ANG_HALF = ANG_W'(1 << (ANG_FRAC - 1));
  localparam logic [DEG_W-1:0]        DEG_90   = DEG_W'(90);
  localparam logic [DEG_W-1:0]        DEG_270  = DEG_W'(270);

  // Configuration port.
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_EW_RES  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NS_RES  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_UP_MODE = 2'd2;

  typedef struct packed {
    logic [RES_W-1:0] ew_res;
    logic [RES_W-1:0] ns_res;
    logic             up_mode;
  } cfg_t;

  // Flags that ride along with each word for the cases settled without CORDIC.
  typedef struct packed {
    logic undef;
    logic flat;
    logic east;
  } spec_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      5'd0:  val = ANG_W'(2949120);
      5'd1:  val = ANG_W'(1740967);
      5'd2:  val = ANG_W'(919879);
      5'd3:  val = ANG_W'(466945);
      5'd4:  val = ANG_W'(234379);
      5'd5:  val = ANG_W'(117304);
      5'd6:  val = ANG_W'(58666);
      5'd7:  val = ANG_W'(29335);
      5'd8:  val = ANG_W'(14668);
      5'd9:  val = ANG_W'(7334);
      5'd10: val = ANG_W'(3667);
      5'd11: val = ANG_W'(1833);
      5'd12: val = ANG_W'(917);
      5'd13: val = ANG_W'(458);
      5'd14: val = ANG_W'(229);
      5'd15: val = ANG_W'(115);
      5'd16: val = ANG_W'(57);
      5'd17: val = ANG_W'(29);
      5'd18: val = ANG_W'(14);
      5'd19: val = ANG_W'(7);
      5'd20: val = ANG_W'(4);
      5'd21: val = ANG_W'(2);
      5'd22: val = ANG_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

  // Sign-extend one elevation sample to gradient width.
  function automatic logic signed [GRAD_W-1:0] sx(input logic signed [ELEV_WIDTH-1:0] v);
    return GRAD_W'(v);
  endfunction

endpackage

// ----- rtl/hasp_regs.sv -----
// Configuration register file of the Horn aspect core, APB-style slave.
// Depends on hasp_pkg for the register map and the cfg_t bundle.
module hasp_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hasp_pkg::PADDR_W-1:0]  paddr,
  input  logic [hasp_pkg::PDATA_W-1:0]  pwdata,
  output logic [hasp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output hasp_pkg::cfg_t                cfg
);

  hasp_pkg::cfg_t cfg_r;
  hasp_pkg::cfg_t cfg_nxt;
  logic [hasp_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[hasp_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        hasp_pkg::REG_EW_RES:  cfg_nxt.ew_res  = pwdata[hasp_pkg::RES_W-1:0];
        hasp_pkg::REG_NS_RES:  cfg_nxt.ns_res  = pwdata[hasp_pkg::RES_W-1:0];
        hasp_pkg::REG_UP_MODE: cfg_nxt.up_mode = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hasp_pkg::REG_EW_RES:  prdata = hasp_pkg::PDATA_W'(cfg_r.ew_res);
      hasp_pkg::REG_NS_RES:  prdata = hasp_pkg::PDATA_W'(cfg_r.ns_res);
      hasp_pkg::REG_UP_MODE: prdata = hasp_pkg::PDATA_W'(cfg_r.up_mode);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ew_res  <= hasp_pkg::RES_W'(1);
      cfg_r.ns_res  <= hasp_pkg::RES_W'(1);
      cfg_r.up_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/horn_aspect_3x3_core.sv -----
// Top level of the Horn aspect core: gradient, scaling and CORDIC pipeline.
// Depends on hasp_pkg and instantiates hasp_regs for the configuration port.
//
//   channel   direction  handshake                 payload
//   in_       input      in_valid / in_stall       eight signed elevation samples
//   out_      output     out_valid / out_stall     aspect_deg, undefined
//   config    input      psel/penable/pwrite/...   ew_resolution, ns_resolution, up_mode
//
// One word enters per clock while in_stall is low; the pipeline has one
// register stage per CORDIC micro-rotation plus the gradient, multiply,
// pre-rotation and output stages.
// Reset (rst_n, synchronous) clears every stage's valid bit and loads the
// resolution registers with 1 and up_mode with 0.
// Each stage holds its word while the stage after it is full and stalled,
// and empty stages keep filling, so words are accepted during an output stall
// until the pipeline is full.
module horn_aspect_3x3_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_nw,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_n,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_ne,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_w,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_e,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_sw,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_s,
  input  logic signed [hasp_pkg::ELEV_WIDTH-1:0] in_elev_se,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [hasp_pkg::DEG_W-1:0]             out_aspect_deg,
  output logic                                   out_undefined,
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [hasp_pkg::PADDR_W-1:0]           paddr,
  input  logic [hasp_pkg::PDATA_W-1:0]           pwdata,
  output logic [hasp_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);

  localparam int N_ROT = hasp_pkg::N_ROT;
  // Stage map: 0 gradient, 1 multiply, 2 pre-rotation, 3..N_ROT+2 micro-rotations,
  // N_ROT+3 output register.
  localparam int NST   = N_ROT + 4;
  localparam int S_OUT = NST - 1;

  hasp_pkg::cfg_t cfg;

  hasp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Flow control. A stage may load when it is empty or its word moves on this
  // cycle; the chain runs back from the output register.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] | rdy[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[S_OUT];

  // ---------------------------------------------------------------------------
  // Stage 0: Horn weighted gradients, west minus east and south minus north.
  // ---------------------------------------------------------------------------
  logic signed [hasp_pkg::GRAD_W-1:0] gx_nxt, gy_nxt;
  logic signed [hasp_pkg::GRAD_W-1:0] gx_r, gy_r;

  always_comb begin
    gx_nxt = (hasp_pkg::sx(in_elev_nw) + (hasp_pkg::sx(in_elev_w) <<< 1)
              + hasp_pkg::sx(in_elev_sw))
           - (hasp_pkg::sx(in_elev_ne) + (hasp_pkg::sx(in_elev_e) <<< 1)
              + hasp_pkg::sx(in_elev_se));
    gy_nxt = (hasp_pkg::sx(in_elev_sw) + (hasp_pkg::sx(in_elev_s) <<< 1)
              + hasp_pkg::sx(in_elev_se))
           - (hasp_pkg::sx(in_elev_nw) + (hasp_pkg::sx(in_elev_n) <<< 1)
              + hasp_pkg::sx(in_elev_ne));
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: scale each gradient by the other axis's spacing. A spacing of
  // zero counts as one. The flat and undefined cases are decided here too.
  // ---------------------------------------------------------------------------
  logic signed [hasp_pkg::RES_W:0]    ns_s, ew_s;
  logic signed [hasp_pkg::PROD_W-1:0] px_nxt, py_nxt;
  logic signed [hasp_pkg::PROD_W-1:0] px_r, py_r;
  hasp_pkg::spec_t                    spec_nxt, spec_mul_r;

  always_comb begin
    ns_s = (cfg.ns_res == '0) ? (hasp_pkg::RES_W+1)'(1) : {1'b0, cfg.ns_res};
    ew_s = (cfg.ew_res == '0) ? (hasp_pkg::RES_W+1)'(1) : {1'b0, cfg.ew_res};
    px_nxt = gx_r * ns_s;
    py_nxt = gy_r * ew_s;
    spec_nxt.flat  = (gy_r == '0);
    spec_nxt.undef = (gy_r == '0) && (gx_r == '0);
    // up_mode mirrors the east/west choice for flat-y cells.
    spec_nxt.east  = (gx_r > 0) ^ cfg.up_mode;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      px_r       <= px_nxt;
      py_r       <= py_nxt;
      spec_mul_r <= spec_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: fold the vector into the right half plane. The CORDIC works on
  // (a, b) = (Y, X); a negative Y is negated and the angle starts at 180.
  // Stages 3 and on: one micro-rotation per register stage.
  // ---------------------------------------------------------------------------
  logic signed [hasp_pkg::CORD_W-1:0] a_r [0:N_ROT];
  logic signed [hasp_pkg::CORD_W-1:0] b_r [0:N_ROT];
  logic signed [hasp_pkg::ANG_W-1:0]  z_r [0:N_ROT];
  hasp_pkg::spec_t                    spec_c_r [0:N_ROT];

  logic signed [hasp_pkg::CORD_W-1:0] a0_nxt, b0_nxt;
  logic signed [hasp_pkg::ANG_W-1:0]  z0_nxt;

  always_comb begin
    if (py_r < 0) begin
      a0_nxt = -hasp_pkg::CORD_W'(py_r);
      b0_nxt = -hasp_pkg::CORD_W'(px_r);
      z0_nxt = hasp_pkg::ANG_180;
    end else begin
      a0_nxt = hasp_pkg::CORD_W'(py_r);
      b0_nxt = hasp_pkg::CORD_W'(px_r);
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      a_r[0]      <= a0_nxt;
      b_r[0]      <= b0_nxt;
      z_r[0]      <= z0_nxt;
      spec_c_r[0] <= spec_mul_r;
    end
  end

  for (genvar j = 0; j < N_ROT; j++) begin : g_rot
    logic signed [hasp_pkg::CORD_W-1:0] da, db, a_nxt, b_nxt;
    logic signed [hasp_pkg::ANG_W-1:0]  ang, z_nxt;

    always_comb begin
      da  = b_r[j] >>> j;
      db  = a_r[j] >>> j;
      ang = hasp_pkg::atan_deg(hasp_pkg::TAB_IDX_W'(j));
      // Drive the cross component toward zero, accumulating the angle turned.
      if (b_r[j] >= 0) begin
        a_nxt = a_r[j] + da;
        b_nxt = b_r[j] - db;
        z_nxt = z_r[j] + ang;
      end else begin
        a_nxt = a_r[j] - da;
        b_nxt = b_r[j] + db;
        z_nxt = z_r[j] - ang;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j+3]) begin
        a_r[j+1]      <= a_nxt;
        b_r[j+1]      <= b_nxt;
        z_r[j+1]      <= z_nxt;
        spec_c_r[j+1] <= spec_c_r[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: wrap into 0..360, round half up to whole degrees, and let
  // the flat and undefined cases override the CORDIC angle. A value just
  // under 360 may round up to 360 and is passed on as such.
  // ---------------------------------------------------------------------------
  hasp_pkg::spec_t                   spec_f;
  logic signed [hasp_pkg::ANG_W-1:0] z_wrap, z_rnd;
  logic [hasp_pkg::DEG_W-1:0]        deg_nxt;
  logic [hasp_pkg::DEG_W-1:0]        deg_r;
  logic                              undef_r;

  always_comb begin
    spec_f = spec_c_r[N_ROT];
    z_wrap = (z_r[N_ROT] < 0) ? z_r[N_ROT] + hasp_pkg::ANG_360 : z_r[N_ROT];
    z_rnd  = z_wrap + hasp_pkg::ANG_HALF;
    if (spec_f.undef) begin
      deg_nxt = '0;
    end else if (spec_f.flat) begin
      deg_nxt = spec_f.east ? hasp_pkg::DEG_90 : hasp_pkg::DEG_270;
    end else begin
      deg_nxt = z_rnd[hasp_pkg::ANG_FRAC +: hasp_pkg::DEG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      deg_r   <= deg_nxt;
      undef_r <= spec_f.undef;
    end
  end

  assign out_aspect_deg = deg_r;
  assign out_undefined  = undef_r;

endmodule
